### design/lzce_pkg.sv
package lzce_pkg;

    // field and register widths
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int THR_W      = 11;
    localparam int PIX_W      = 8;
    localparam int LAP_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // 2*width+2 with width below 2048 fits here
    localparam int WARM_W     = 13;

    localparam int MAX_HEIGHT = 4096;

    // register reset values
    localparam int RST_WIDTH  = 1024;
    localparam int RST_HEIGHT = 768;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } t_cfg_idx;

    typedef logic [PIX_W-1:0]        t_pix;
    typedef logic signed [LAP_W-1:0] t_lap;

endpackage

### design/lzce_pix_if.sv
interface lzce_pix_if import lzce_pkg::*; ();
    logic valid;
    logic ready;
    logic mode;
    t_pix pixel_value;

    modport source (output valid, output mode, output pixel_value, input ready);
    modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

### design/lzce_res_if.sv
interface lzce_res_if ();
    logic valid;
    logic ready;
    logic edge_mark;
    logic frame_end;

    modport source (output valid, output edge_mark, output frame_end, input ready);
    modport sink   (input valid, input edge_mark, input frame_end, output ready);
endinterface

### design/lzce_line_mem.sv
module lzce_line_mem #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // column write
    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // prefetch read, write data forwarded when both hit one column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/laplacian_zero_crossing_edges_top.sv
// channel  dir  handshake     payload
// i_pix    in   valid/ready   mode, pixel_value
// o_res    out  valid/ready   edge_mark, frame_end
// cfg      in   i_cfg_we      i_cfg_idx, i_cfg_data
//
// one item per cycle while no held result stalls the input; the result for raster position p leaves
// with item p+2*width+2 and is held in the output register, valid in the cycle after that item
// two column memories (pixels, laplacians) are read one column ahead; the pixel memory is written back
// on every counted item, the laplacian memory only once laplacians are active; the single read port per
// memory sets the one-item-per-cycle rate; reset clears configuration, counters and the output valid only,
// windows, output data and column memories hold no reset value; a held result stalls input only when o_res.ready is low
module laplacian_zero_crossing_edges_top import lzce_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lzce_pix_if.sink              i_pix,
    lzce_res_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (XW > WIDTH_W) ? XW : WIDTH_W;

    // configuration
    logic [WIDTH_W-1:0]       r_width;
    logic [HEIGHT_W-1:0]      r_height;
    logic signed [THR_W-1:0]  r_thr;

    // counters
    logic [XW-1:0]       r_xn, n_xn, r_xq, n_xq, r_xp, n_xp;
    logic [HEIGHT_W-1:0] r_yn, n_yn, r_yq, n_yq, r_yp, n_yp;
    logic [WARM_W-1:0]   r_warm, n_warm;

    // windows
    t_pix r_wp1 [3];
    t_pix r_wp2 [3];
    t_lap r_wl1 [3];
    t_lap r_wl2 [3];

    // output register
    logic r_ov, r_edge, r_fend;

    logic [2*PIX_W-1:0] pcol, pcol_wr;
    logic [2*LAP_W-1:0] lcol, lcol_wr;

    logic              acc, step, emit, lap_act, last, restart;
    logic [CMPW-1:0]   w_last;
    logic [WARM_W-1:0] lead, lap_start;
    logic [WIDTH_W-1:0] cfg_w;
    logic [HEIGHT_W-1:0] cfg_h;

    // widths and derived limits
    assign w_last    = CMPW'(r_width - 1'b1);
    assign lead      = WARM_W'({r_width, 1'b0}) + WARM_W'(2);
    assign lap_start = WARM_W'(r_width) + WARM_W'(1);

    // handshake
    assign i_pix.ready = !r_ov || o_res.ready;
    assign acc     = i_pix.valid && i_pix.ready;
    assign step    = acc && ((r_yn >= r_height) || !i_pix.mode);
    assign lap_act = r_warm >= lap_start;
    assign emit    = step && (r_warm == lead);
    assign last    = (CMPW'(r_xp) == w_last) && (r_yp == r_height - 1'b1);
    assign restart = emit && last;

    // laplacian of the window center, borders replicated
    t_pix p_c, p_up, p_dn, p_lf, p_rt;
    logic [PIX_W+1:0]     psum;
    logic signed [LAP_W:0] lap12;
    t_lap lap;

    always_comb begin
        p_c  = r_wp1[1];
        p_up = (r_yq == '0) ? p_c : r_wp1[0];
        p_dn = (r_yq == r_height - 1'b1) ? p_c : r_wp1[2];
        p_lf = (r_xq == '0) ? p_c : r_wp2[1];
        p_rt = (CMPW'(r_xq) == w_last) ? p_c : pcol[PIX_W-1:0];
        psum = (PIX_W+2)'(p_up) + (PIX_W+2)'(p_dn) + (PIX_W+2)'(p_lf) + (PIX_W+2)'(p_rt);
        lap12 = signed'({2'b00, psum}) - signed'({2'b00, p_c, 2'b00});
        lap   = lap12[LAP_W-1:0];
    end

    // zero-crossing test, neighbors outside the image read as zero
    t_lap l_c, l_up, l_dn, l_lf, l_rt;
    logic signed [LAP_W:0] thr12, nthr12;
    logic edge_hit;

    always_comb begin
        l_c  = r_wl1[1];
        l_up = (r_yp == '0) ? t_lap'(0) : r_wl1[0];
        l_dn = (r_yp == r_height - 1'b1) ? t_lap'(0) : r_wl1[2];
        l_lf = (r_xp == '0) ? t_lap'(0) : r_wl2[1];
        l_rt = (CMPW'(r_xp) == w_last) ? t_lap'(0) : lcol[LAP_W-1:0];
        thr12  = (LAP_W+1)'(r_thr);
        nthr12 = -thr12;
        edge_hit = ((LAP_W+1)'(l_c) >= thr12) &&
                   (((LAP_W+1)'(l_up) < nthr12) || ((LAP_W+1)'(l_dn) < nthr12) ||
                    ((LAP_W+1)'(l_lf) < nthr12) || ((LAP_W+1)'(l_rt) < nthr12));
    end

    // next counter values
    always_comb begin
        n_xn = r_xn; n_yn = r_yn;
        n_xq = r_xq; n_yq = r_yq;
        n_xp = r_xp; n_yp = r_yp;
        n_warm = r_warm;
        if (restart) begin
            n_xn = '0; n_yn = '0;
            n_xq = '0; n_yq = '0;
            n_xp = '0; n_yp = '0;
            n_warm = '0;
        end else if (step) begin
            if (CMPW'(r_xn) == w_last) begin
                n_xn = '0;
                n_yn = r_yn + 1'b1;
            end else begin
                n_xn = r_xn + 1'b1;
            end
            if (lap_act) begin
                if (CMPW'(r_xq) == w_last) begin
                    n_xq = '0;
                    n_yq = r_yq + 1'b1;
                end else begin
                    n_xq = r_xq + 1'b1;
                end
            end
            if (emit) begin
                if (CMPW'(r_xp) == w_last) begin
                    n_xp = '0;
                    n_yp = r_yp + 1'b1;
                end else begin
                    n_xp = r_xp + 1'b1;
                end
            end
            if (r_warm != lead) begin
                n_warm = r_warm + 1'b1;
            end
        end
    end

    // write-back data: older row moves up, new value enters below
    assign pcol_wr = {pcol[PIX_W-1:0], i_pix.pixel_value};
    assign lcol_wr = {lcol[LAP_W-1:0], lap};

    lzce_line_mem #(.DATA_W(2*PIX_W), .DEPTH(MAX_WIDTH)) u_pix_mem (
        .i_clk   (i_clk),
        .i_en    (step),
        .i_we    (1'b1),
        .i_waddr (r_xn),
        .i_wdata (pcol_wr),
        .i_raddr (n_xn),
        .o_rdata (pcol)
    );

    lzce_line_mem #(.DATA_W(2*LAP_W), .DEPTH(MAX_WIDTH)) u_lap_mem (
        .i_clk   (i_clk),
        .i_en    (step),
        .i_we    (lap_act),
        .i_waddr (r_xq),
        .i_wdata (lcol_wr),
        .i_raddr (n_xq),
        .o_rdata (lcol)
    );

    // clamped register values
    always_comb begin
        cfg_w = i_cfg_data[WIDTH_W-1:0];
        if (cfg_w == '0) begin
            cfg_w = WIDTH_W'(1);
        end else if (32'(cfg_w) > MAX_WIDTH) begin
            cfg_w = WIDTH_W'(MAX_WIDTH);
        end
        cfg_h = i_cfg_data[HEIGHT_W-1:0];
        if (cfg_h == '0) begin
            cfg_h = HEIGHT_W'(1);
        end else if (32'(cfg_h) > MAX_HEIGHT) begin
            cfg_h = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    // configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= (RST_WIDTH > MAX_WIDTH) ? WIDTH_W'(MAX_WIDTH) : WIDTH_W'(RST_WIDTH);
            r_height <= HEIGHT_W'(RST_HEIGHT);
            r_thr    <= '0;
            r_xn <= '0; r_yn <= '0;
            r_xq <= '0; r_yq <= '0;
            r_xp <= '0; r_yp <= '0;
            r_warm <= '0;
        end else begin
            r_xn <= n_xn; r_yn <= n_yn;
            r_xq <= n_xq; r_yq <= n_yq;
            r_xp <= n_xp; r_yp <= n_yp;
            r_warm <= n_warm;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_IMAGE_WIDTH: begin
                        r_width <= cfg_w;
                        r_xn <= '0; r_yn <= '0;
                        r_xq <= '0; r_yq <= '0;
                        r_xp <= '0; r_yp <= '0;
                        r_warm <= '0;
                    end
                    CFG_IMAGE_HEIGHT: begin
                        r_height <= cfg_h;
                        r_xn <= '0; r_yn <= '0;
                        r_xq <= '0; r_yq <= '0;
                        r_xp <= '0; r_yp <= '0;
                        r_warm <= '0;
                    end
                    CFG_THRESHOLD: begin
                        r_thr <= i_cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // window shift, one column per counted item
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_wp2 <= r_wp1;
            r_wp1[0] <= pcol[2*PIX_W-1:PIX_W];
            r_wp1[1] <= pcol[PIX_W-1:0];
            r_wp1[2] <= i_pix.pixel_value;
            r_wl2 <= r_wl1;
            r_wl1[0] <= lcol[2*LAP_W-1:LAP_W];
            r_wl1[1] <= lcol[LAP_W-1:0];
            r_wl1[2] <= lap;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_edge <= edge_hit;
            r_fend <= last;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.edge_mark = r_edge;
    assign o_res.frame_end = r_fend;

    // checks
    a_warm_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_warm <= lead)
        else $error("warm-up count passed the lead");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CMPW'(r_xn) <= w_last) && (CMPW'(r_xp) <= w_last))
        else $error("column counter beyond image width");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (restart && !i_cfg_we) |=> (r_warm == '0) && (r_xn == '0) && (r_yn == '0))
        else $error("frame did not restart after its last result");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |-> !emit)
        else $error("result produced while output held");

endmodule
